// ===== rtl/itp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and precedence helpers for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

   // transaction codes
   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_END  = 1'b1;

   localparam logic STAT_OK       = 1'b0;
   localparam logic STAT_OVERFLOW = 1'b1;

   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UZ     = 8'h5A;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LZ     = 8'h7A;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_CLOSE
   } itp_state_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] wr_data;
   } stack_cmd_type;

   typedef struct packed {
      logic       empty;
      logic       full;
      logic [7:0] top;
   } stack_stat_type;

   function automatic logic [1:0] prec_of(input logic [7:0] c);
      logic [1:0] p;
      case (c)
         CH_PLUS, CH_MINUS:  p = 2'd1;
         CH_STAR, CH_SLASH:  p = 2'd2;
         CH_CARET, CH_DOLLAR: p = 2'd3;
         default:            p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return c inside {[CH_0:CH_9], [CH_UA:CH_UZ], [CH_LA:CH_LZ]};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/infix_to_postfix_converter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard converter: one infix character per request transaction,
// postfix characters out, operator stack kept in a synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one character (req_type = 0) or an end mark (req_type = 1).
//   rsp_* carries zero or more result transactions per request; the last one
//   of a request has rsp_last_of_run set. An end mark flushes the stack and
//   finishes with a terminator (rsp_expr_done = 1, rsp_char_out = 0). A push
//   onto a full stack gives one result with rsp_status = 1 and the character.
// Timing:
//   a letter or digit goes straight to the output register; its result is on rsp_* the next cycle.
//   Any other request enters ST_EVAL, which pops stack entries one at a time
//   and then pushes, discards or finishes; ST_CLOSE is added when entries
//   were popped and a terminator or overflow follows. The stack top is read
//   from the memory each cycle. One request is worked on at a time.
// Reset:
//   synchronous; empties the stack (count only, the memory is not cleared)
//   and drops any result not yet taken.
// Stall:
//   results wait in a one-deep hold register and the output register; the
//   block pauses while a result cannot move on, and resumes without loss.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_type,
   input  wire logic [7:0] req_char_in,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_char_out,
   output logic            rsp_status,
   output logic            rsp_expr_done,
   output logic            rsp_last_of_run
);

   itp_state_type  state_ff, state_in;
   stack_cmd_type  stk_cmd;
   stack_stat_type stk_stat;

   logic       cur_end_ff;
   logic [7:0] cur_char_ff;

   logic       pend_valid_ff, pend_valid_in;
   logic [7:0] pend_char_ff;
   logic       pend_status_ff;
   logic       pend_done_ff;

   logic       rsp_valid_ff;
   logic [7:0] rsp_char_ff;
   logic       rsp_status_ff;
   logic       rsp_done_ff;
   logic       rsp_last_ff;

   logic       accept;
   logic       out_free;
   logic       is_lp, is_rp;
   logic       pop_cond, discard, do_push;
   logic       fin_res;
   logic [7:0] fin_char;
   logic       fin_status;
   logic       need_out, step_go;

   logic       out_load;
   logic [7:0] out_char;
   logic       out_status, out_done, out_last;
   logic       pend_load, pend_clear;
   logic [7:0] pend_char;
   logic       pend_status, pend_done;

   itp_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stk_cmd),
      .stat  (stk_stat)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   // decision for the current request against the stack top
   always_comb begin
      is_lp    = (cur_char_ff == CH_LPAREN);
      is_rp    = (cur_char_ff == CH_RPAREN);
      pop_cond = !stk_stat.empty &&
                 ((cur_end_ff == REQ_END) ||
                  (!is_lp && (is_rp ? (stk_stat.top != CH_LPAREN)
                                    : (prec_of(stk_stat.top) >= prec_of(cur_char_ff)))));
      discard  = (cur_end_ff == REQ_CHAR) && is_rp && !stk_stat.empty;
      do_push  = (cur_end_ff == REQ_CHAR) && !is_rp && !stk_stat.full;
      fin_res  = (cur_end_ff == REQ_END) || (!is_rp && stk_stat.full);
      fin_char   = (cur_end_ff == REQ_END) ? CH_NUL : cur_char_ff;
      fin_status = (cur_end_ff == REQ_END) ? STAT_OK : STAT_OVERFLOW;
      need_out = pend_valid_ff || (!pop_cond && fin_res);
      step_go  = !need_out || out_free;
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      out_load    = 1'b0;
      out_char    = pend_char_ff;
      out_status  = pend_status_ff;
      out_done    = pend_done_ff;
      out_last    = 1'b0;
      pend_load   = 1'b0;
      pend_clear  = 1'b0;
      pend_char   = stk_stat.top;
      pend_status = STAT_OK;
      pend_done   = 1'b0;
      stk_cmd.push    = 1'b0;
      stk_cmd.pop     = 1'b0;
      stk_cmd.wr_data = cur_char_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (accept && (req_type == REQ_CHAR) && is_alnum(req_char_in)) begin
               out_load   = 1'b1;
               out_char   = req_char_in;
               out_status = STAT_OK;
               out_done   = 1'b0;
               out_last   = 1'b1;
            end
         end
         ST_EVAL: begin
            if (step_go) begin
               if (pop_cond) begin
                  // popped entry waits in the hold register until we know if it is last
                  out_load    = pend_valid_ff;
                  pend_load   = 1'b1;
                  stk_cmd.pop = 1'b1;
               end else if (fin_res) begin
                  if (pend_valid_ff) begin
                     out_load    = 1'b1;
                     pend_load   = 1'b1;
                     pend_char   = fin_char;
                     pend_status = fin_status;
                     pend_done   = (cur_end_ff == REQ_END);
                  end else begin
                     out_load   = 1'b1;
                     out_char   = fin_char;
                     out_status = fin_status;
                     out_done   = (cur_end_ff == REQ_END);
                     out_last   = 1'b1;
                  end
               end else begin
                  stk_cmd.push = do_push;
                  stk_cmd.pop  = discard;
                  out_load     = pend_valid_ff;
                  out_last     = 1'b1;
                  pend_clear   = 1'b1;
               end
            end
         end
         ST_CLOSE: begin
            if (out_free) begin
               out_load   = 1'b1;
               out_last   = 1'b1;
               pend_clear = 1'b1;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !((req_type == REQ_CHAR) && is_alnum(req_char_in))) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (step_go && !pop_cond) begin
               state_in = (fin_res && pend_valid_ff) ? ST_CLOSE : ST_IDLE;
            end
         end
         ST_CLOSE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign pend_valid_in = pend_load ? 1'b1 : (pend_clear ? 1'b0 : pend_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_end_ff  <= req_type;
         cur_char_ff <= req_char_in;
      end
      if (pend_load) begin
         pend_char_ff   <= pend_char;
         pend_status_ff <= pend_status;
         pend_done_ff   <= pend_done;
      end
      if (out_load) begin
         rsp_char_ff   <= out_char;
         rsp_status_ff <= out_status;
         rsp_done_ff   <= out_done;
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_expr_done   = rsp_done_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held result left over between transactions");

   a_term_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_expr_done) |-> rsp_last_of_run)
      else $error("terminator not marked last");

   a_ovf_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_OVERFLOW)) |-> rsp_last_of_run)
      else $error("overflow result not marked last");

endmodule
`default_nettype wire

// ===== rtl/itp_stack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itp_stack
// Operator stack: a one-port-write, one-port-read synchronous memory with a
// fill count. The top entry is read every cycle and held in a register, with
// the pushed byte forwarded when it lands on the entry being read.
// ----------------------------------------------------------------------------
module itp_stack
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire stack_cmd_type  cmd,
   output stack_stat_type      stat
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [7:0]    mem [STACK_DEPTH];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [7:0]    top_ff;

   assign count_in = count_ff + CW'(cmd.push) - CW'(cmd.pop);
   assign wr_addr  = count_ff[AW-1:0];
   // next top lives one below the next count
   assign rd_addr  = (count_in == '0) ? '0 : AW'(count_in - CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_addr] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push && (rd_addr == wr_addr)) begin
         top_ff <= cmd.wr_data;
      end else begin
         top_ff <= mem[rd_addr];
      end
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(STACK_DEPTH));
   assign stat.top   = top_ff;

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !stat.full)
      else $error("push onto full stack");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !stat.empty)
      else $error("pop from empty stack");

   a_push_is_top: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> (stat.top == $past(cmd.wr_data)) && !stat.empty)
      else $error("pushed byte not seen on top");

   a_single_op: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.pop))
      else $error("push and pop in one cycle");

endmodule
`default_nettype wire
